// ===== sv/xlbi_pkg.sv =====
package xlbi_pkg;

    // fixed field widths of the item and result
    localparam int VALUE_W   = 40;
    localparam int PIVOT_W   = 6;
    localparam int RANK_W    = 6;
    localparam int SUM_W     = 46;

    // default word width of the basis
    localparam int WORD_BITS_DEF = 40;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic [PIVOT_W-1:0] pivot_bit;
        logic [RANK_W-1:0]  rank;
        logic [SUM_W-1:0]   weight_sum;
    } res_t;

    // control that travels along the chain with the partly reduced word
    typedef struct packed {
        logic               valid;
        logic               placed;
        logic [PIVOT_W-1:0] pivot;
    } token_t;

endpackage

// ===== sv/xlbi_cell.sv =====
module xlbi_cell
    import xlbi_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CELL_IDX  = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  token_t               in_ctl,
    input  logic [WORD_BITS-1:0] in_work,
    output token_t               out_ctl,
    output logic [WORD_BITS-1:0] out_work
);

    logic [WORD_BITS-1:0] row_reg;
    logic [WORD_BITS-1:0] row_next;
    token_t               ctl_reg;
    token_t               ctl_next;
    logic [WORD_BITS-1:0] work_reg;
    logic [WORD_BITS-1:0] work_next;
    logic                 hit;
    logic                 empty;

    // this cell owns the pivot bit CELL_IDX
    assign hit   = in_ctl.valid & ~in_ctl.placed & in_work[CELL_IDX];
    assign empty = (row_reg == '0);

    always_comb
    begin
        row_next  = row_reg;
        ctl_next  = in_ctl;
        work_next = in_work;
        if (clear)
        begin
            row_next = '0;
        end
        else if (hit && empty)
        begin
            row_next        = in_work;
            ctl_next.placed = 1'b1;
            ctl_next.pivot  = PIVOT_W'(CELL_IDX);
        end
        else if (hit)
        begin
            work_next = in_work ^ row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            ctl_reg  <= '0;
            work_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            ctl_reg  <= ctl_next;
            work_reg <= work_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_work = work_reg;

endmodule

// ===== sv/xor_linear_basis_insert.sv =====
// xor linear basis over gf(2) with one row per pivot bit. an insert item walks down a
// chain of WORD_BITS cells, one cell a cycle from the top bit to bit 0; each cell either
// folds its stored row into the word or, when empty, keeps the word as its new row.
// an insert keeps busy high from the accepting edge until the item leaves the bottom cell,
// so no new item is taken while it walks the chain; a clear leaves busy low and empties every
// row at the accepting edge. busy stays high while an insert is in the chain. each item
// gives exactly one result, shown for one cycle with strobe high; the receiver cannot
// stall it, so it must take the result in that cycle. value bits above WORD_BITS are
// ignored, and the weight sum wraps at 46 bits.
module xor_linear_basis_insert
    import xlbi_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic strobe,
    output res_t result
);

    localparam int EXT_W = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;

    logic                 take;
    logic                 take_clear;
    logic                 take_insert;
    logic [EXT_W-1:0]     value_ext;
    logic [WORD_BITS-1:0] value_masked;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 inj_valid_reg;
    logic [WORD_BITS-1:0] inj_work_reg;
    logic [WORD_BITS-1:0] orig_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    res_t                 res_reg;
    res_t                 res_next;

    // chain links: index WORD_BITS feeds the top cell, index 0 leaves the bottom cell
    token_t               ctl_chain  [WORD_BITS+1];
    logic [WORD_BITS-1:0] work_chain [WORD_BITS+1];

    assign take        = start & ~busy_reg;
    assign take_clear  = take & (request.cmd == CMD_CLEAR);
    assign take_insert = take & (request.cmd == CMD_INSERT);

    // keep only the low WORD_BITS bits of the value
    assign value_ext    = EXT_W'(request.value);
    assign value_masked = value_ext[WORD_BITS-1:0];

    // injection into the top cell
    assign ctl_chain[WORD_BITS].valid  = inj_valid_reg;
    assign ctl_chain[WORD_BITS].placed = 1'b0;
    assign ctl_chain[WORD_BITS].pivot  = '0;
    assign work_chain[WORD_BITS]       = inj_work_reg;

    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_cell
        xlbi_cell #(
            .WORD_BITS (WORD_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (take_clear),
            .in_ctl   (ctl_chain[i+1]),
            .in_work  (work_chain[i+1]),
            .out_ctl  (ctl_chain[i]),
            .out_work (work_chain[i])
        );
    end

    // result assembly: on a clear, or when the item leaves the bottom cell; an accepted insert raises busy
    always_comb
    begin
        busy_next      = busy_reg;
        sum_next       = sum_reg;
        rank_next      = rank_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        if (take_clear)
        begin
            sum_next            = '0;
            rank_next           = '0;
            res_valid_next      = 1'b1;
            res_next.accepted   = 1'b0;
            res_next.pivot_bit  = '0;
            res_next.rank       = '0;
            res_next.weight_sum = '0;
        end
        else if (take_insert)
        begin
            busy_next = 1'b1;
        end
        else if (ctl_chain[0].valid)
        begin
            busy_next      = 1'b0;
            res_valid_next = 1'b1;
            if (ctl_chain[0].placed)
            begin
                sum_next  = sum_reg + SUM_W'(orig_reg);
                rank_next = rank_reg + RANK_W'(1);
            end
            res_next.accepted   = ctl_chain[0].placed;
            res_next.pivot_bit  = ctl_chain[0].placed ? ctl_chain[0].pivot : '0;
            res_next.rank       = rank_next;
            res_next.weight_sum = sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            inj_valid_reg <= 1'b0;
            sum_reg       <= '0;
            rank_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            inj_valid_reg <= take_insert;
            sum_reg       <= sum_next;
            rank_reg      <= rank_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_insert)
        begin
            inj_work_reg <= value_masked;
            orig_reg     <= value_masked;
        end
        res_reg <= res_next;
    end

    assign busy   = busy_reg;
    assign strobe = res_valid_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg <= RANK_W'(WORD_BITS))
        else $error("rank exceeds word width");

    a_pivot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.accepted) |-> (res_reg.pivot_bit == '0))
        else $error("pivot set on a dependent result");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_clear |=> (res_valid_reg && res_reg.rank == '0 && res_reg.weight_sum == '0))
        else $error("clear did not give an empty result");

    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take_insert |=> (busy_reg && !res_valid_reg))
        else $error("insert did not raise busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !busy_reg)
        else $error("result shown while an item is in the chain");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;

    import xlbi_pkg::*;

    // the block is built at its default word width
    localparam int WORD_BITS = WORD_BITS_DEF;
    // items wanted in the random part
    localparam int RANDOM_ITEMS = 400;
    // idle cycles allowed for the last results to come in
    localparam int DRAIN_LIMIT = 1000;

    // one line of the directed table: the item, and a result typed in by hand
    // where it can be read off at a glance
    typedef struct {
        req_t item;
        logic pinned;
        res_t outcome;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic strobe;
    res_t result;

    // hand-typed result travelling alongside the item now on the request port
    logic pin_now;
    res_t pin_outcome;

    // mirror of the basis, kept in step with every accepted item
    logic [VALUE_W-1:0] basis_mirror [WORD_BITS];
    logic [SUM_W-1:0]   sum_mirror;
    logic [RANK_W-1:0]  rank_mirror;

    // results still owed by the block, oldest first
    res_t pending_outcomes [$];
    int errors;

    // sender pacing: items left in the current burst
    int burst_left;

    directed_row_t directed_tab [$];

    xor_linear_basis_insert dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // hard stop in case the block hangs or never drops busy
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // works out the result of one item and moves the mirror on; the word is
    // reduced from the top bit down, folding in stored rows until it either
    // vanishes (dependent) or lands in an empty slot
    function automatic res_t basis_outcome(input req_t item);
        res_t               r;
        logic [VALUE_W-1:0] w;
        logic               done;
        int                 b;
        r = '0;
        if (item.cmd == CMD_CLEAR)
        begin
            foreach (basis_mirror[i])
                basis_mirror[i] = '0;
            sum_mirror  = '0;
            rank_mirror = '0;
        end
        else
        begin
            w    = item.value;
            done = 1'b0;
            for (b = WORD_BITS - 1; b >= 0; b--)
            begin
                if (!done && w[b])
                begin
                    if (basis_mirror[b] == '0)
                    begin
                        // independent: keep the partly reduced word, add the original
                        basis_mirror[b] = w;
                        sum_mirror      = sum_mirror + SUM_W'(item.value);
                        rank_mirror     = rank_mirror + RANK_W'(1);
                        r.accepted      = 1'b1;
                        r.pivot_bit     = PIVOT_W'(b);
                        done            = 1'b1;
                    end
                    else
                        w = w ^ basis_mirror[b];
                end
            end
        end
        r.rank       = rank_mirror;
        r.weight_sum = sum_mirror;
        return r;
    endfunction

    function automatic directed_row_t dir_row(input logic cmd, input logic [VALUE_W-1:0] value,
                                              input logic pinned, input logic acc,
                                              input int piv, input int rnk,
                                              input logic [SUM_W-1:0] sum);
        directed_row_t d;
        d.item.cmd            = cmd;
        d.item.value          = value;
        d.pinned              = pinned;
        d.outcome.accepted    = acc;
        d.outcome.pivot_bit   = PIVOT_W'(piv);
        d.outcome.rank        = RANK_W'(rnk);
        d.outcome.weight_sum  = sum;
        return d;
    endfunction

    // puts one item on the port and holds it until the block takes it
    task automatic send_item(input req_t item, input logic pinned, input res_t outcome);
        start       <= 1'b1;
        request     <= item;
        pin_now     <= pinned;
        pin_outcome <= outcome;
        do
            @(posedge clk);
        while (busy);
    endtask

    // bursts of random length with random gaps; long gaps land on every phase
    // of the walk down the cell chain, and some bursts run with no gap at all
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 1) == 0)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(1, WORD_BITS + 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(0, 8);
        end
    endtask

    function automatic logic [VALUE_W-1:0] full_word();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // picks the next random item; most are inserts of varied density, some are
    // combinations of stored rows so that they must come out dependent
    function automatic req_t random_item();
        req_t               it;
        logic [VALUE_W-1:0] span;
        int                 pick;
        int                 b;
        it.cmd   = CMD_INSERT;
        it.value = full_word();
        pick     = $urandom_range(0, 99);
        if (pick < 3)
            it.cmd = CMD_CLEAR;
        else if (pick < 25)
        begin
            // xor of a random subset of the stored rows, possibly zero
            span = '0;
            for (b = 0; b < WORD_BITS; b++)
                if ($urandom_range(0, 1) == 1)
                    span = span ^ basis_mirror[b];
            it.value = span;
        end
        else if (pick < 40)
            it.value = full_word() >> $urandom_range(0, WORD_BITS - 1);
        else if (pick < 50)
            it.value = VALUE_W'(1) << $urandom_range(0, WORD_BITS - 1);
        else if (pick < 57)
            it.value = ~(VALUE_W'(1) << $urandom_range(0, WORD_BITS - 1));
        else if (pick < 60)
            it.value = ($urandom_range(0, 1) == 1) ? '1 : '0;
        return it;
    endfunction

    // accepts items and checks results at the same edge, so a result can never
    // be looked at before its own expectation has been queued
    always @(posedge clk)
    begin : watch
        res_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = basis_outcome(request);
                if (pin_now)
                    want = pin_outcome;
                pending_outcomes.insert(pending_outcomes.size(), want);
            end
            if (strobe)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t unexpected result: expected none got %0h", $time, result);
                    errors++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result.accepted !== want.accepted)
                    begin
                        $display("%0t accepted: expected %0h got %0h",
                                 $time, want.accepted, result.accepted);
                        errors++;
                    end
                    if (result.pivot_bit !== want.pivot_bit)
                    begin
                        $display("%0t pivot_bit: expected %0d got %0d",
                                 $time, want.pivot_bit, result.pivot_bit);
                        errors++;
                    end
                    if (result.rank !== want.rank)
                    begin
                        $display("%0t rank: expected %0d got %0d",
                                 $time, want.rank, result.rank);
                        errors++;
                    end
                    if (result.weight_sum !== want.weight_sum)
                    begin
                        $display("%0t weight_sum: expected %0h got %0h",
                                 $time, want.weight_sum, result.weight_sum);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        req_t item;
        res_t none;
        int   n_random;
        int   episode_left;
        int   drain;

        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        pin_now     = 1'b0;
        pin_outcome = '0;
        none        = '0;
        errors      = 0;
        burst_left  = 0;
        n_random    = 0;
        foreach (basis_mirror[i])
            basis_mirror[i] = '0;
        sum_mirror  = '0;
        rank_mirror = '0;

        // directed part: zero and all-ones words, dependence, clears with live
        // state and with a value that must be ignored, both ends of the pivot range
        directed_tab = '{
            dir_row(CMD_INSERT, 40'h00_0000_0000, 1'b1, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_CLEAR,  40'h00_0000_0000, 1'b1, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'hFF_FFFF_FFFF, 1'b1, 1'b1, 39, 1, 46'hFF_FFFF_FFFF),
            dir_row(CMD_INSERT, 40'hFF_FFFF_FFFF, 1'b1, 1'b0, 0,  1, 46'hFF_FFFF_FFFF),
            dir_row(CMD_INSERT, 40'h00_0000_0001, 1'b1, 1'b1, 0,  2, 46'h100_0000_0000),
            dir_row(CMD_INSERT, 40'h80_0000_0000, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'hFF_FFFF_FFFE, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h00_0000_0000, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_CLEAR,  40'h12_3456_789A, 1'b1, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h00_0000_0001, 1'b1, 1'b1, 0,  1, 46'h1),
            dir_row(CMD_INSERT, 40'h00_0000_0002, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h00_0000_0003, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h55_5555_5555, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'hAA_AAAA_AAAA, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h80_0000_0001, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h00_0001_0000, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h7F_FFFF_FFFF, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h0F_0F0F_0F0F, 1'b0, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_CLEAR,  40'h00_0000_0000, 1'b1, 1'b0, 0,  0, 46'h0),
            dir_row(CMD_INSERT, 40'h80_0000_0000, 1'b1, 1'b1, 39, 1, 46'h80_0000_0000),
            dir_row(CMD_INSERT, 40'h40_0000_0000, 1'b1, 1'b1, 38, 2, 46'hC0_0000_0000),
            dir_row(CMD_INSERT, 40'hC0_0000_0000, 1'b1, 1'b0, 0,  2, 46'hC0_0000_0000),
            dir_row(CMD_CLEAR,  40'hFF_FFFF_FFFF, 1'b1, 1'b0, 0,  0, 46'h0)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tab[i])
        begin
            send_item(directed_tab[i].item, directed_tab[i].pinned, directed_tab[i].outcome);
            pace_sender();
        end

        // random part in episodes: usually a clear, then a run of inserts long
        // enough in many cases to fill all forty rows and go on past full rank
        while (n_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                item.cmd   = CMD_CLEAR;
                item.value = full_word();
                send_item(item, 1'b0, none);
                pace_sender();
                n_random++;
            end
            episode_left = $urandom_range(5, 70);
            while (episode_left > 0 && n_random < RANDOM_ITEMS)
            begin
                send_item(random_item(), 1'b0, none);
                pace_sender();
                n_random++;
                episode_left--;
            end
        end

        start <= 1'b0;

        // wait for the last results, then a little longer for stray strobes
        drain = 0;
        while (pending_outcomes.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (WORD_BITS + 4) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t missing results: expected %0d more got 0",
                     $time, pending_outcomes.size());
            errors++;
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/xlbi_pkg.sv
sv/xlbi_cell.sv
sv/xor_linear_basis_insert.sv
sim/testbench.sv
